>>> hw/rtl/sam_pkg.sv
`default_nettype none
package sam_pkg;
  localparam int unsigned SymW = 7;
  localparam int unsigned NodeW = 12;
  localparam int unsigned TotW = 25;
  localparam int unsigned StatW = 2;
  localparam int unsigned MaxNodes = 4096;
  localparam int unsigned Alphabet = 128;
  localparam logic [StatW-1:0] StatOk = 2'd0;
  localparam logic [StatW-1:0] StatFull = 2'd1;
  localparam logic [StatW-1:0] StatNoNode = 2'd2;
  localparam logic [TotW-1:0] TotalMax = {TotW{1'b1}};
endpackage
`default_nettype wire

>>> hw/rtl/suffix_automaton_extend.sv
// timing: data dependent; the result beat comes in the cycle after accept for an unknown node;
//   a reuse passes S_RD0, S_RD1, S_DRYQ, S_DRYQ2; otherwise suffix-link hops are walked in
//   S_DRY/S_DRYL and S_WALK/S_WALK2, S_CLR clears the new row, a clone copies rows in S_CPRD/S_CPWR
// throughput: one item at a time, busy_o high from the accept edge through the result beat
// reset: node count 1, total 0; a clearing pass in S_INIT zeroes the root row,
//   busy_o is high meanwhile; the result beat is a one-cycle strobe, the receiver cannot stall
`default_nettype none
module suffix_automaton_extend (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic busy_o,
  input  wire logic [sam_pkg::SymW-1:0] symbol_i,
  input  wire logic [sam_pkg::NodeW-1:0] from_node_i,
  output logic done_o,
  output logic [sam_pkg::NodeW-1:0] result_node_o,
  output logic [sam_pkg::StatW-1:0] status_o,
  output logic [sam_pkg::TotW-1:0] distinct_substrings_o
);
  localparam int unsigned MAX_NODES = sam_pkg::MaxNodes;
  localparam int unsigned ALPHABET = sam_pkg::Alphabet;
  localparam int unsigned NW = sam_pkg::NodeW;
  localparam int unsigned AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int unsigned MW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned TW = MW + AW;

  // sequencer states
  localparam logic [4:0] S_INIT = 5'd0, S_IDLE = 5'd1, S_RD0 = 5'd2, S_RD1 = 5'd3,
    S_DRY = 5'd4, S_DRYL = 5'd5, S_DRYQ = 5'd6, S_DRYQ2 = 5'd7, S_CLR = 5'd8,
    S_WALK = 5'd9, S_WALK2 = 5'd10, S_WLEN = 5'd11, S_WLEN2 = 5'd12,
    S_CPRD = 5'd13, S_CPWR = 5'd14, S_RLNK = 5'd15, S_RLNK2 = 5'd16,
    S_RW = 5'd17, S_RW2 = 5'd18, S_FIN = 5'd19, S_DONE = 5'd20, S_CPD = 5'd21;

  // memories: transitions, lengths, links
  logic [NW-1:0] tt_mem [MAX_NODES*ALPHABET];
  logic [NW-1:0] len_mem [MAX_NODES];
  logic [NW-1:0] lnk_mem [MAX_NODES];
  logic [NW-1:0] tt_rd_q, len_rd_q, lnk_rd_q;
  logic [TW-1:0] tt_ra, tt_wa;
  logic [NW-1:0] tt_wd;
  logic tt_we;
  logic [MW-1:0] len_ra, len_wa, lnk_ra, lnk_wa;
  logic [NW-1:0] len_wd, lnk_wd;
  logic len_we, lnk_we;

  always_ff @(posedge clk_i) begin
    if (tt_we) tt_mem[tt_wa] <= tt_wd;
    tt_rd_q <= tt_mem[tt_ra];
    if (len_we) len_mem[len_wa] <= len_wd;
    len_rd_q <= len_mem[len_ra];
    if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
    lnk_rd_q <= lnk_mem[lnk_ra];
  end

  logic [4:0] st_q, st_d;
  logic [AW-1:0] sym_q, sym_d, idx_q, idx_d;
  logic [NW-1:0] from_q, from_d, p_q, p_d, q_q, q_d, cur_q, cur_d, cl_q, cl_d;
  logic [NW-1:0] lfrom_q, lfrom_d, lp_q, lp_d, lk_q, lk_d, len_q, len_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [sam_pkg::TotW-1:0] tot_q, tot_d;
  logic [sam_pkg::StatW-1:0] stat_q, stat_d;
  logic [NW-1:0] res_q, res_d;
  logic newn_q, newn_d;  // new-node path (vs reuse/clone from from_node)
  logic clret_q, clret_d; // after clone, return to finish of new node
  logic [1:0] need_q, need_d;

  function automatic logic [TW-1:0] ta(input logic [NW-1:0] n, input logic [AW-1:0] s);
    ta = {n[MW-1:0], s};
  endfunction

  logic [AW-1:0] sym_red;
  always_comb begin
    sym_red = AW'(32'(symbol_i) % ALPHABET);
  end

  always_comb begin
    st_d = st_q; sym_d = sym_q; idx_d = idx_q; from_d = from_q; p_d = p_q;
    q_d = q_q; cur_d = cur_q; cl_d = cl_q; lfrom_d = lfrom_q; lp_d = lp_q;
    lk_d = lk_q; len_d = len_q; cnt_d = cnt_q; tot_d = tot_q; stat_d = stat_q;
    res_d = res_q; newn_d = newn_q; clret_d = clret_q; need_d = need_q;
    tt_ra = ta(p_q, sym_q); tt_wa = ta(p_q, sym_q); tt_wd = '0; tt_we = 1'b0;
    len_ra = p_q[MW-1:0]; len_wa = '0; len_wd = '0; len_we = 1'b0;
    lnk_ra = p_q[MW-1:0]; lnk_wa = '0; lnk_wd = '0; lnk_we = 1'b0;
    unique case (st_q)
      S_INIT: begin
        tt_wa = ta('0, idx_q); tt_we = 1'b1;
        len_we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (32'(idx_q) == ALPHABET - 1) st_d = S_IDLE;
      end
      S_IDLE: if (start_i) begin
        sym_d = sym_red; from_d = from_node_i; p_d = from_node_i;
        if (CW'(from_node_i) >= cnt_q) begin
          stat_d = sam_pkg::StatNoNode; res_d = '0; st_d = S_DONE;
        end else begin
          stat_d = sam_pkg::StatOk; st_d = S_RD0;
        end
      end
      // read T[from][sym] and len[from]
      S_RD0: begin len_ra = from_q[MW-1:0]; st_d = S_RD1; end
      S_RD1: begin
        lfrom_d = len_rd_q; q_d = tt_rd_q;
        if (tt_rd_q != '0) begin
          len_ra = tt_rd_q[MW-1:0]; st_d = S_DRYQ;
        end else begin
          need_d = 2'd1; p_d = from_q; st_d = S_DRY;
        end
      end
      S_DRYQ: begin len_ra = q_q[MW-1:0]; st_d = S_DRYQ2; end
      S_DRYQ2: begin
        if (len_rd_q == lfrom_q + 1'b1) begin
          res_d = q_q; st_d = S_DONE;
        end else if (32'(cnt_q) + 1 > MAX_NODES) begin
          stat_d = sam_pkg::StatFull; res_d = '0; st_d = S_DONE;
        end else begin
          newn_d = 1'b0; clret_d = 1'b0; lp_d = lfrom_q; p_d = from_q;
          cl_d = NW'(cnt_q); len_d = lfrom_q + 1'b1; idx_d = '0; st_d = S_CPRD;
        end
      end
      // dry walk: p's tt/len/link were read at p_q addresses (issued last cycle)
      S_DRY: st_d = S_DRYL;
      S_DRYL: begin
        if (tt_rd_q != '0) begin
          q_d = tt_rd_q; lp_d = len_rd_q; len_ra = tt_rd_q[MW-1:0];
          st_d = S_WLEN;
        end else if (p_q == '0) begin
          st_d = S_WLEN2; need_d = 2'd1;
        end else begin
          p_d = lnk_rd_q; st_d = S_DRY;
        end
      end
      S_WLEN: begin len_ra = q_q[MW-1:0]; st_d = S_WLEN2; need_d = 2'd3; end
      S_WLEN2: begin
        if (need_q == 2'd3) need_d = (lp_q + 1'b1 != len_rd_q) ? 2'd2 : 2'd1;
        st_d = S_CLR;
        if (need_q == 2'd3) st_d = S_WLEN2;
        if (need_q != 2'd3) begin
          if (32'(cnt_q) + 32'(need_q) > MAX_NODES) begin
            stat_d = sam_pkg::StatFull; res_d = '0; st_d = S_DONE;
          end else begin
            cur_d = NW'(cnt_q); cnt_d = cnt_q + 1'b1; idx_d = '0;
            newn_d = 1'b1; p_d = from_q;
          end
        end
      end
      S_CLR: begin
        tt_wa = ta(cur_q, idx_q); tt_we = 1'b1;
        len_wa = cur_q[MW-1:0]; len_wd = lfrom_q + 1'b1; len_we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (32'(idx_q) == ALPHABET - 1) begin st_d = S_WALK; lk_d = '0; end
      end
      // real walk: set T[p][sym]=cur until a transition exists
      S_WALK: st_d = S_WALK2;
      S_WALK2: begin
        if (tt_rd_q != '0) begin
          q_d = tt_rd_q; lp_d = len_rd_q; len_ra = tt_rd_q[MW-1:0];
          st_d = S_RLNK;
        end else begin
          tt_wd = cur_q; tt_we = 1'b1;
          if (p_q == '0) begin lk_d = '0; len_ra = '0; st_d = S_FIN; end
          else begin p_d = lnk_rd_q; st_d = S_WALK; end
        end
      end
      S_RLNK: begin len_ra = q_q[MW-1:0]; st_d = S_RLNK2; end
      S_RLNK2: begin
        if (lp_q + 1'b1 == len_rd_q) begin
          lk_d = q_q; len_ra = q_q[MW-1:0]; st_d = S_FIN;
        end else begin
          clret_d = 1'b1; cl_d = NW'(cnt_q); len_d = lp_q + 1'b1;
          idx_d = '0; st_d = S_CPRD;
        end
      end
      // clone: copy row of q, then link and redirect
      S_CPRD: begin tt_ra = ta(q_q, idx_q); st_d = S_CPWR; end
      S_CPWR: begin
        tt_wa = ta(cl_q, idx_q); tt_wd = tt_rd_q; tt_we = 1'b1;
        idx_d = idx_q + 1'b1;
        lnk_ra = q_q[MW-1:0];
        st_d = (32'(idx_q) == ALPHABET - 1) ? S_CPD : S_CPRD;
      end
      S_CPD: begin
        lnk_ra = q_q[MW-1:0];
        len_wa = cl_q[MW-1:0]; len_wd = len_q; len_we = 1'b1;
        st_d = S_RW;
      end
      S_RW: begin
        st_d = S_RW2;
        // clone inherits q's link on the first pass only
        lnk_wa = cl_q[MW-1:0]; lnk_wd = lnk_rd_q;
        lnk_we = (idx_q == '0);
        idx_d = '1;
      end
      S_RW2: begin
        if (tt_rd_q != q_q) begin
          lnk_wa = q_q[MW-1:0]; lnk_wd = cl_q; lnk_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (clret_q) begin lk_d = cl_q; len_ra = cl_q[MW-1:0]; st_d = S_FIN; end
          else begin res_d = cl_q; st_d = S_DONE; end
        end else begin
          tt_wd = cl_q; tt_we = 1'b1;
          if (p_q == '0) begin
            lnk_wa = q_q[MW-1:0]; lnk_wd = cl_q; lnk_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
            if (clret_q) begin lk_d = cl_q; len_ra = cl_q[MW-1:0]; st_d = S_FIN; end
            else begin res_d = cl_q; st_d = S_DONE; end
          end else begin p_d = lnk_rd_q; st_d = S_RW; end
        end
      end
      S_FIN: begin
        // len_rd_q now holds len[lk]; it moves to lp_q while len_q takes the new node's length
        lnk_wa = cur_q[MW-1:0]; lnk_wd = lk_q; lnk_we = 1'b1;
        len_d = lfrom_q + 1'b1;
        lp_d = len_rd_q;
        st_d = S_DONE; res_d = cur_q;
      end
      S_DONE: begin
        if (newn_q && stat_q == sam_pkg::StatOk) begin
          tot_d = ({1'b0, tot_q} + (sam_pkg::TotW+1)'(len_q - lp_q) > {1'b0, sam_pkg::TotalMax})
            ? sam_pkg::TotalMax : tot_q + sam_pkg::TotW'(len_q - lp_q);
        end
        newn_d = 1'b0;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; idx_q <= '0; cnt_q <= CW'(1); tot_q <= '0;
      newn_q <= 1'b0; stat_q <= sam_pkg::StatOk;
    end else begin
      st_q <= st_d; idx_q <= idx_d; cnt_q <= cnt_d; tot_q <= tot_d;
      newn_q <= newn_d; stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; from_q <= from_d; p_q <= p_d; q_q <= q_d; cur_q <= cur_d;
    cl_q <= cl_d; lfrom_q <= lfrom_d; lp_q <= lp_d; lk_q <= lk_d; len_q <= len_d;
    res_q <= res_d; clret_q <= clret_d; need_q <= need_d;
  end

  assign busy_o = (st_q != S_IDLE);
  assign done_o = (st_q == S_DONE);
  assign result_node_o = res_q;
  assign status_o = stat_q;
  assign distinct_substrings_o = (newn_q && stat_q == sam_pkg::StatOk) ?
    ((({1'b0, tot_q} + (sam_pkg::TotW+1)'(len_q - lp_q)) > {1'b0, sam_pkg::TotalMax})
      ? sam_pkg::TotalMax : tot_q + sam_pkg::TotW'(len_q - lp_q)) : tot_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_NODES) else $error("node count over capacity");
  a_err_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != sam_pkg::StatOk |-> result_node_o == '0)
    else $error("error beat with nonzero node");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
endmodule
`default_nettype wire

>>> dv/suffix_automaton_extend_checker.sv
`default_nettype none
module suffix_automaton_extend_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic busy_i,
  input  wire logic [sam_pkg::SymW-1:0] symbol_i,
  input  wire logic [sam_pkg::NodeW-1:0] from_node_i,
  input  wire logic done_i,
  input  wire logic [sam_pkg::NodeW-1:0] result_node_i,
  input  wire logic [sam_pkg::StatW-1:0] status_i,
  input  wire logic [sam_pkg::TotW-1:0] distinct_substrings_i,
  output int fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_NODES = sam_pkg::MaxNodes;
  localparam int unsigned ALPHABET = sam_pkg::Alphabet;
  localparam int unsigned SymW = sam_pkg::SymW;
  localparam int unsigned NodeW = sam_pkg::NodeW;
  localparam int unsigned StatW = sam_pkg::StatW;
  localparam int unsigned TotW = sam_pkg::TotW;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [StatW-1:0] stat;
    logic [TotW-1:0]  total;
  } sam_result_t;

  // shadow automaton
  logic [NodeW-1:0] len_mem [MAX_NODES];
  logic [NodeW-1:0] link_mem [MAX_NODES];
  logic [NodeW-1:0] goto_mem [MAX_NODES*ALPHABET];
  int unsigned      node_cnt;
  logic [TotW-1:0]  substr_total;

  sam_result_t expected_q [$];
  int          mismatches;

  function automatic int unsigned goto_idx(int unsigned n, int unsigned s);
    return n * ALPHABET + s;
  endfunction

  function automatic int unsigned clone_node(int unsigned p, int unsigned q,
                                             int unsigned s, int unsigned lenv);
    int unsigned cl;
    cl = node_cnt;
    node_cnt++;
    len_mem[cl] = NodeW'(lenv);
    for (int unsigned k = 0; k < ALPHABET; k++) goto_mem[goto_idx(cl, k)] =
      goto_mem[goto_idx(q, k)];
    link_mem[cl] = link_mem[q];
    forever begin
      if (32'(goto_mem[goto_idx(p, s)]) != q) break;
      goto_mem[goto_idx(p, s)] = NodeW'(cl);
      if (p == 0) break;
      p = 32'(link_mem[p]);
    end
    link_mem[q] = NodeW'(cl);
    return cl;
  endfunction

  function automatic sam_result_t extend(logic [SymW-1:0] sym_in,
                                         logic [NodeW-1:0] from);
    sam_result_t r;
    int unsigned s, f, q, p, cur, lk, need, sum;
    bit found;
    s = 32'(sym_in) % ALPHABET;
    f = 32'(from);
    r.node = '0;
    r.stat = sam_pkg::StatOk;
    found = 0;
    if (f >= node_cnt) begin
      r.stat = sam_pkg::StatNoNode;
    end else begin
      // count the nodes this extension needs
      q = 32'(goto_mem[goto_idx(f, s)]);
      if (q != 0) begin
        need = (32'(len_mem[q]) == 32'(len_mem[f]) + 1) ? 0 : 1;
      end else begin
        need = 1;
        p = f;
        forever begin
          if (goto_mem[goto_idx(p, s)] != '0) begin
            found = 1;
            break;
          end
          if (p == 0) break;
          p = 32'(link_mem[p]);
        end
        if (found && 32'(len_mem[p]) + 1 != 32'(len_mem[goto_mem[goto_idx(p, s)]]))
          need = 2;
      end
      if (node_cnt + need > MAX_NODES) r.stat = sam_pkg::StatFull;
    end
    if (r.stat == sam_pkg::StatOk) begin
      q = 32'(goto_mem[goto_idx(f, s)]);
      if (q != 0) begin
        if (32'(len_mem[q]) == 32'(len_mem[f]) + 1) r.node = NodeW'(q);
        else r.node = NodeW'(clone_node(f, q, s, 32'(len_mem[f]) + 1));
      end else begin
        cur = node_cnt;
        node_cnt++;
        len_mem[cur] = NodeW'(32'(len_mem[f]) + 1);
        for (int unsigned k = 0; k < ALPHABET; k++) goto_mem[goto_idx(cur, k)] = '0;
        lk = 0;
        found = 0;
        p = f;
        forever begin
          if (goto_mem[goto_idx(p, s)] != '0) begin
            found = 1;
            break;
          end
          goto_mem[goto_idx(p, s)] = NodeW'(cur);
          if (p == 0) break;
          p = 32'(link_mem[p]);
        end
        if (found) begin
          q = 32'(goto_mem[goto_idx(p, s)]);
          if (32'(len_mem[p]) + 1 == 32'(len_mem[q])) lk = q;
          else lk = clone_node(p, q, s, 32'(len_mem[p]) + 1);
        end
        link_mem[cur] = NodeW'(lk);
        sum = 32'(substr_total) + 32'(len_mem[cur]) - 32'(len_mem[lk]);
        substr_total = (sum > 32'(sam_pkg::TotalMax)) ? sam_pkg::TotalMax : TotW'(sum);
        r.node = NodeW'(cur);
      end
    end
    r.total = substr_total;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sam_result_t exp_r;
    if (!rst_ni) begin
      node_cnt = 1;
      substr_total = '0;
      len_mem[0] = '0;
      for (int unsigned k = 0; k < ALPHABET; k++) goto_mem[k] = '0;
      expected_q.delete();
      mismatches = 0;
      fails_o <= 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: node %0d status %0d",
                 result_node_i, status_i);
          mismatches++;
        end else begin
          exp_r = expected_q.pop_front();
          if (result_node_i !== exp_r.node) begin
            $error("result_node expected %0d actual %0d", exp_r.node, result_node_i);
            mismatches++;
          end
          if (status_i !== exp_r.stat) begin
            $error("status expected %0d actual %0d", exp_r.stat, status_i);
            mismatches++;
          end
          if (distinct_substrings_i !== exp_r.total) begin
            $error("distinct_substrings expected %0d actual %0d", exp_r.total,
                   distinct_substrings_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(extend(symbol_i, from_node_i));
      fails_o <= mismatches + expected_q.size();
    end
  end
endmodule
`default_nettype wire

>>> dv/suffix_automaton_extend_tb.sv
`default_nettype none
module suffix_automaton_extend_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Alphabet = sam_pkg::Alphabet;
  localparam int unsigned SymW = sam_pkg::SymW;
  localparam int unsigned NodeW = sam_pkg::NodeW;
  localparam int unsigned StatW = sam_pkg::StatW;
  localparam int unsigned TotW = sam_pkg::TotW;
  localparam int unsigned RandomBeats = 1500;
  localparam int unsigned ChainBeats = 350;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [SymW-1:0] symbol_i = '0;
  logic [NodeW-1:0] from_node_i = '0;
  logic busy_o, done_o;
  logic [NodeW-1:0] result_node_o;
  logic [StatW-1:0] status_o;
  logic [TotW-1:0] distinct_substrings_o;
  int fails;

  // beat bookkeeping seen from the result side
  int sent_cnt, done_cnt, ok_cnt, full_cnt, nonode_cnt;
  logic [NodeW-1:0] chain_node;
  logic [NodeW-1:0] known_nodes [$];

  always #5 clk_i = ~clk_i;

  suffix_automaton_extend DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .symbol_i, .from_node_i,
    .done_o, .result_node_o, .status_o, .distinct_substrings_o
  );

  suffix_automaton_extend_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .symbol_i, .from_node_i,
    .done_i(done_o), .result_node_i(result_node_o), .status_i(status_o),
    .distinct_substrings_i(distinct_substrings_o), .fails_o(fails)
  );

  // track returned nodes so stimulus can walk the trie like real use
  always @(posedge clk_i) begin
    if (done_o) begin
      done_cnt++;
      case (status_o)
        sam_pkg::StatOk: begin
          ok_cnt++;
          chain_node = result_node_o;
          known_nodes.push_back(result_node_o);
        end
        sam_pkg::StatFull: full_cnt++;
        default: nonode_cnt++;
      endcase
    end
  end

  // one command beat, then wait for its result so the next one can chain on it
  task automatic issue(input logic [SymW-1:0] sym, input logic [NodeW-1:0] from);
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    start_i <= 1'b1;
    symbol_i <= sym;
    from_node_i <= from;
    @(negedge clk_i);
    start_i <= 1'b0;
    sent_cnt++;
    while (done_cnt != sent_cnt) @(negedge clk_i);
  endtask

  // random burst of idle cycles on the command side
  task automatic maybe_idle();
    if ($urandom_range(3) == 0) repeat ($urandom_range(19, 1)) @(negedge clk_i);
  endtask

  function automatic logic [NodeW-1:0] pick_from();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return chain_node;
    if (sel < 85 && known_nodes.size() > 0)
      return known_nodes[$urandom_range(known_nodes.size() - 1)];
    if (sel < 92) return '0;
    return NodeW'($urandom);
  endfunction

  function automatic logic [SymW-1:0] pick_symbol();
    // a tiny alphabet forces reuse, clones and long suffix-link walks
    if ($urandom_range(3) != 0) return SymW'($urandom_range(2));
    return SymW'($urandom);
  endfunction

  initial begin
    chain_node = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: root extremes, reuse, a clone on reuse, unallocated nodes
    issue(SymW'(1), '0);
    issue(SymW'(2), chain_node);
    issue(SymW'(2), '0);
    issue('0, '0);
    issue({SymW{1'b1}}, '0);
    issue({SymW{1'b1}}, '0);
    issue('0, {NodeW{1'b1}});
    issue(SymW'(5), NodeW'(1000));
    issue(SymW'(1), chain_node);
    issue(SymW'(1), chain_node);
    issue(SymW'(2), '0);
    issue(SymW'(1), '0);
    issue({SymW{1'b1}}, chain_node);

    // random trie walks with idle bursts
    for (int i = 0; i < RandomBeats; i++) begin
      maybe_idle();
      issue(pick_symbol(), pick_from());
    end

    // no idling from here: long random-symbol chains
    for (int i = 0; i < ChainBeats; i++) begin
      if ($urandom_range(15) == 0) issue(pick_symbol(), pick_from());
      else issue(SymW'($urandom), chain_node);
    end
    repeat (40) issue(pick_symbol(), pick_from());

    wait (done_cnt == sent_cnt);
    repeat (2 * Alphabet + 50) @(posedge clk_i);
    $display("%0d command beats: %0d extended, %0d store full, %0d unknown node",
             sent_cnt, ok_cnt, full_cnt, nonode_cnt);
    $display("trie walks with reuse and clones, final substring total %0d",
             distinct_substrings_o);
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire

>>> suffix_automaton_extend.f
hw/rtl/sam_pkg.sv
hw/rtl/suffix_automaton_extend.sv
dv/suffix_automaton_extend_checker.sv
dv/suffix_automaton_extend_tb.sv
